>>> sv/swcd_pkg.sv
`timescale 1ns / 1ps

package swcd_pkg;

    localparam int SYNC_BYTES   = 8;
    localparam int HEADER_BYTES = 4;
    localparam int CHECK_BYTES  = 4;
    localparam int WIN_W        = 8 * SYNC_BYTES;
    localparam int LANE_W       = (SYNC_BYTES > 1) ? $clog2(SYNC_BYTES) : 1;
    localparam int FILL_W       = $clog2(SYNC_BYTES + 1);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd2000;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_WORD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

    localparam int TDATA_W = 48;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HEADER,
        PH_CHECK,
        PH_KEEP,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msg_type;
        logic [7:0]  aux_byte;
        logic [15:0] payload_size;
        logic        payload_kept;
        logic [7:0]  data_byte;
        logic        frame_ok;
        logic        last_of_frame;
    } result_t;

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/swcd_core.sv
`timescale 1ns / 1ps

module swcd_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    input  logic [7:0]             in_byte,
    input  logic [63:0]            sync_word,
    input  logic [15:0]            max_payload,
    output logic                   wr0,
    output logic                   wr1,
    output swcd_pkg::result_t      res0,
    output swcd_pkg::result_t      res1
);

    localparam int NL = swcd_pkg::SYNC_BYTES;
    localparam int LW = swcd_pkg::LANE_W;
    localparam int WW = swcd_pkg::WIN_W;
    localparam int FW = swcd_pkg::FILL_W;

    swcd_pkg::phase_t phase_reg, phase_next;
    logic [WW-1:0]    window_reg, window_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [2:0]       field_reg, field_next;
    logic [31:0]      header_reg, header_next;
    logic [31:0]      check_reg, check_next;
    logic [31:0]      crc_reg, crc_next;
    logic [15:0]      left_reg, left_next;
    logic [LW-1:0]    ptr_reg, ptr_next;
    logic [LW-1:0]    sel;
    logic [31:0]      lane_reg [NL];
    logic [31:0]      lane_next [NL];
    logic [WW-1:0]    shifted;
    logic             kept_now;
    logic             finish;
    logic             ok;
    swcd_pkg::result_t base;

    // one CRC lane per window position; the lane opened on the oldest byte of the
    // window holds the CRC of exactly the current window
    assign sel = (ptr_reg == LW'(NL - 1)) ? '0 : ptr_reg + LW'(1);
    assign shifted = WW'(window_reg >> 8);
    assign kept_now = (header_reg[15:0] != 16'd0) && (header_reg[15:0] <= max_payload);

    always_comb begin
        for (int j = 0; j < NL; j++) begin
            lane_next[j] = swcd_pkg::crc_byte((LW'(j) == ptr_reg) ? swcd_pkg::CRC_INIT
                                                                   : lane_reg[j], in_byte);
        end
    end

    always_comb begin
        base.kind          = swcd_pkg::KIND_HEADER;
        base.msg_type      = header_reg[31:24];
        base.aux_byte      = header_reg[23:16];
        base.payload_size  = header_reg[15:0];
        base.payload_kept  = kept_now;
        base.data_byte     = 8'd0;
        base.frame_ok      = 1'b0;
        base.last_of_frame = 1'b0;

        phase_next  = phase_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        field_next  = field_reg;
        header_next = header_reg;
        check_next  = check_reg;
        crc_next    = crc_reg;
        left_next   = left_reg;
        ptr_next    = ptr_reg;
        finish      = 1'b0;
        ok          = 1'b0;
        wr0         = 1'b0;
        wr1         = 1'b0;
        res0        = base;
        res1        = base;

        if (in_valid) begin
            unique case (phase_reg)
                swcd_pkg::PH_HUNT: begin
                    window_next = shifted | (WW'(in_byte) << (WW - 8));
                    if (fill_reg < FW'(NL)) begin
                        fill_next = fill_reg + FW'(1);
                    end
                    ptr_next = sel;
                    if (fill_next == FW'(NL) && window_next == sync_word[WW-1:0]) begin
                        crc_next    = lane_next[sel];
                        phase_next  = swcd_pkg::PH_HEADER;
                        field_next  = 3'd0;
                        header_next = 32'd0;
                        check_next  = 32'd0;
                    end
                end
                swcd_pkg::PH_HEADER: begin
                    header_next = {header_reg[23:0], in_byte};
                    crc_next    = swcd_pkg::crc_byte(crc_reg, in_byte);
                    field_next  = field_reg + 3'd1;
                    if (field_next >= 3'(swcd_pkg::HEADER_BYTES)) begin
                        field_next = 3'd0;
                        phase_next = swcd_pkg::PH_CHECK;
                    end
                end
                swcd_pkg::PH_CHECK: begin
                    check_next = {check_reg[23:0], in_byte};
                    field_next = field_reg + 3'd1;
                    if (field_next >= 3'(swcd_pkg::CHECK_BYTES)) begin
                        field_next = 3'd0;
                        wr0        = 1'b1;
                        left_next  = header_reg[15:0];
                        if (header_reg[15:0] == 16'd0) begin
                            finish = 1'b1;
                            ok     = (~crc_reg == check_next);
                            wr1    = 1'b1;
                            res1.kind          = swcd_pkg::KIND_STATUS;
                            res1.frame_ok      = ok;
                            res1.last_of_frame = 1'b1;
                        end else begin
                            phase_next = kept_now ? swcd_pkg::PH_KEEP : swcd_pkg::PH_SKIP;
                        end
                    end
                end
                swcd_pkg::PH_KEEP: begin
                    crc_next       = swcd_pkg::crc_byte(crc_reg, in_byte);
                    wr0            = 1'b1;
                    res0.kind      = swcd_pkg::KIND_PAYLOAD;
                    res0.data_byte = in_byte;
                    left_next      = left_reg - 16'd1;
                    if (left_next == 16'd0) begin
                        finish = 1'b1;
                        ok     = (~crc_next == check_reg);
                        wr1    = 1'b1;
                        res1.kind          = swcd_pkg::KIND_STATUS;
                        res1.frame_ok      = ok;
                        res1.last_of_frame = 1'b1;
                    end
                end
                swcd_pkg::PH_SKIP: begin
                    left_next = left_reg - 16'd1;
                    if (left_next == 16'd0) begin
                        finish = 1'b1;
                        ok     = (~crc_reg == check_reg);
                        wr0    = 1'b1;
                        res0.kind          = swcd_pkg::KIND_STATUS;
                        res0.frame_ok      = ok;
                        res0.last_of_frame = 1'b1;
                    end
                end
                default: begin
                    phase_next  = swcd_pkg::PH_HUNT;
                    fill_next   = '0;
                    window_next = '0;
                end
            endcase
            if (finish) begin
                phase_next  = swcd_pkg::PH_HUNT;
                fill_next   = '0;
                window_next = '0;
                field_next  = 3'd0;
                left_next   = 16'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= swcd_pkg::PH_HUNT;
            window_reg <= '0;
            fill_reg   <= '0;
            field_reg  <= 3'd0;
            header_reg <= 32'd0;
            check_reg  <= 32'd0;
            crc_reg    <= swcd_pkg::CRC_INIT;
            left_reg   <= 16'd0;
            ptr_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            field_reg  <= field_next;
            header_reg <= header_next;
            check_reg  <= check_next;
            crc_reg    <= crc_next;
            left_reg   <= left_next;
            ptr_reg    <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && phase_reg == swcd_pkg::PH_HUNT) begin
            for (int j = 0; j < NL; j++) begin
                lane_reg[j] <= lane_next[j];
            end
        end
    end

    a_second_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        wr1 |-> (wr0 && res1.kind == swcd_pkg::KIND_STATUS))
        else $error("second result is not a status");

    a_hunt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && phase_reg == swcd_pkg::PH_HUNT) |-> !wr0)
        else $error("result emitted while hunting");

    a_payload_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr0 && res0.kind == swcd_pkg::KIND_PAYLOAD) |=>
            (phase_reg == swcd_pkg::PH_KEEP || phase_reg == swcd_pkg::PH_HUNT))
        else $error("payload beat outside kept payload");

endmodule

>>> sv/swcd_fifo.sv
`timescale 1ns / 1ps

module swcd_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          wr0,
    input  logic                          wr1,
    input  swcd_pkg::result_t             d0,
    input  swcd_pkg::result_t             d1,
    input  logic                          pop,
    output logic                          out_valid,
    output swcd_pkg::result_t             out_data,
    output logic [swcd_pkg::FIFO_CW-1:0]  count
);

    localparam int AW = swcd_pkg::FIFO_AW;
    localparam int CW = swcd_pkg::FIFO_CW;

    swcd_pkg::result_t mem [swcd_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_wr;

    assign n_wr      = CW'(wr0) + CW'(wr1);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(n_wr);
        rd_ptr_next = rd_ptr_reg + AW'(pop && out_valid);
        count_next  = count_reg + n_wr - CW'(pop && out_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr0) begin
            mem[wr_ptr_reg] <= d0;
        end
        if (wr1) begin
            mem[wr_ptr_reg + AW'(1)] <= d1;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr0 |-> ((count_reg + n_wr) <= CW'(swcd_pkg::FIFO_DEPTH)))
        else $error("result queue overflow");

endmodule

>>> sv/sync_word_crc32_deframer.sv
`timescale 1ns / 1ps

// Sync-word deframer with CRC-32 check. Takes one received byte per beat and
// can accept a byte on every clock while s_tready is high. A byte is
// registered, then processed: sliding 8-byte sync search (eight parallel
// byte-wide CRC lanes give the sync word's CRC on match), 4-byte header,
// 4-byte big-endian checksum, payload. Each byte yields zero, one or two
// result beats (header info plus status for an empty frame, last payload
// byte plus status); they go into an 8-entry result queue, and s_tready
// drops when that queue, after the results of the byte in flight, could not
// take two more. No clearing pass after reset.
module sync_word_crc32_deframer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // rx_byte
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // msg_type, aux_byte, payload_size, payload_kept, data_byte, frame_ok, zero pad
    output logic [swcd_pkg::TDATA_W-1:0]        m_tdata,
    output logic [1:0]                          m_tuser,   // result_kind
    output logic                                m_tlast,   // last_of_frame
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [63:0]                         cfg_data
);

    localparam int CW = swcd_pkg::FIFO_CW;

    logic [63:0]       sync_word_reg;
    logic [15:0]       max_payload_reg;
    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              wr0, wr1;
    swcd_pkg::result_t res0, res1, head;
    logic [CW-1:0]     count;

    assign cfg_ready = 1'b1;
    assign s_tready  = (count + (in_valid_reg ? CW'(2) : CW'(0)))
                       <= CW'(swcd_pkg::FIFO_DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg   <= 64'd0;
            max_payload_reg <= swcd_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                swcd_pkg::CFG_SYNC_WORD:   sync_word_reg   <= cfg_data;
                swcd_pkg::CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[15:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    swcd_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (in_valid_reg),
        .in_byte     (in_byte_reg),
        .sync_word   (sync_word_reg),
        .max_payload (max_payload_reg),
        .wr0         (wr0),
        .wr1         (wr1),
        .res0        (res0),
        .res1        (res1)
    );

    swcd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr0       (wr0),
        .wr1       (wr1),
        .d0        (res0),
        .d1        (res1),
        .pop       (m_tready),
        .out_valid (m_tvalid),
        .out_data  (head),
        .count     (count)
    );

    assign m_tdata = {6'd0, head.frame_ok, head.data_byte, head.payload_kept,
                      head.payload_size, head.aux_byte, head.msg_type};
    assign m_tuser = head.kind;
    assign m_tlast = head.last_of_frame;

endmodule
